// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property checked on every rising edge of clk while arst_n is high.
`define ODF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication that must hold on the edge after the antecedent.
`define ODF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ODF_ASSERT(lbl, prop, msg)
`define ODF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/odf_pkg.sv =====
// ---------------------------------------------------------------------------
// Ogg page deframer package
// Shared constants, result codes and the transaction type for the queue.
// ---------------------------------------------------------------------------
package odf_pkg;

	localparam int ODF_MAX_SEGMENTS = 255;

	// Result kinds.
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// Header byte positions.
	localparam logic [4:0] HDR_VERSION  = 5'd4;
	localparam logic [4:0] HDR_FLAGS    = 5'd5;
	localparam logic [4:0] HDR_GRANULE  = 5'd6;
	localparam logic [4:0] HDR_SERIAL   = 5'd14;
	localparam logic [4:0] HDR_SEQUENCE = 5'd18;
	localparam logic [4:0] HDR_CRC      = 5'd22;
	localparam logic [4:0] HDR_SEGCOUNT = 5'd26;

	// Capture pattern "OggS".
	localparam logic [7:0] CAPTURE [4] = '{8'h4F, 8'h67, 8'h67, 8'h53};

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  version;
		logic [7:0]  page_flags;
		logic [63:0] granule_position;
		logic [31:0] stream_serial;
		logic [31:0] page_sequence;
		logic [31:0] crc_field;
		logic [7:0]  segment_count;
		logic [7:0]  payload_byte;
		logic        segment_end;
		logic        page_end;
	} odf_tok_t;

	typedef struct packed {
		logic full;
		logic empty;
	} odf_qstat_t;

endpackage

// ===== rtl/odf_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module odf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 255,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/odf_front.sv =====
// ---------------------------------------------------------------------------
// Ogg page deframer front end
// Parses the byte stream, captures header fields, keeps the segment table and
// turns each accepted byte into at most one result transaction.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module odf_front import odf_pkg::*; #(
	parameter int MAX_SEGMENTS = ODF_MAX_SEGMENTS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  odf_qstat_t q_stat,
	output logic       q_push,
	output odf_tok_t   q_tok
);

	localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_TABLE   = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;
	localparam logic [1:0] PH_HALT    = 2'd3;

	logic [1:0]  phase_q;
	logic [4:0]  hdr_cnt_q;
	logic [7:0]  tbl_idx_q;
	logic [7:0]  nz_cnt_q;
	logic [7:0]  seg_idx_q;
	logic [7:0]  cur_left_q;
	logic        next_from_reg_q;

	logic [7:0]  version_q;
	logic [7:0]  flags_q;
	logic [63:0] granule_q;
	logic [31:0] serial_q;
	logic [31:0] sequence_q;
	logic [31:0] crc_q;
	logic [7:0]  segs_q;
	logic [7:0]  first_q;
	logic [7:0]  second_q;

	logic        accept;
	logic [8:0]  tbl_sum;
	logic        store_ok;
	logic [7:0]  nz_next;
	logic        tbl_done;
	logic [7:0]  left_dec;
	logic        seg_done;
	logic        seg_last;
	logic        sig_bad;
	logic [8:0]  raddr_sum;
	logic [7:0]  ram_rdata;
	logic        ram_we;
	logic        ram_re;
	odf_tok_t    hdr_tok;
	odf_tok_t    tok;
	logic        push;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		tbl_sum   = {1'b0, tbl_idx_q} + 9'd1;
		store_ok  = ({1'b0, tbl_idx_q} < 9'(MAX_SEGMENTS)) && (in_byte != 8'd0);
		nz_next   = nz_cnt_q + {7'd0, store_ok};
		tbl_done  = tbl_sum >= {1'b0, segs_q};
		left_dec  = cur_left_q - 8'd1;
		seg_done  = left_dec == 8'd0;
		seg_last  = seg_idx_q == (nz_cnt_q - 8'd1);
		sig_bad   = (hdr_cnt_q < HDR_VERSION) && (in_byte != CAPTURE[hdr_cnt_q[1:0]]);
		raddr_sum = {1'b0, seg_idx_q} + 9'd2;

		hdr_tok                  = '0;
		hdr_tok.kind             = KIND_HEADER;
		hdr_tok.version          = version_q;
		hdr_tok.page_flags       = flags_q;
		hdr_tok.granule_position = granule_q;
		hdr_tok.stream_serial    = serial_q;
		hdr_tok.page_sequence    = sequence_q;
		hdr_tok.crc_field        = crc_q;
		hdr_tok.segment_count    = segs_q;

		tok  = '0;
		push = 1'b0;
		case (phase_q)
			PH_HEADER: begin
				if (sig_bad) begin
					tok.kind = KIND_ERROR;
					push     = 1'b1;
				end else if ((hdr_cnt_q == HDR_SEGCOUNT) && (in_byte == 8'd0)) begin
					tok               = hdr_tok;
					tok.segment_count = in_byte;
					push              = 1'b1;
				end
			end
			PH_TABLE: begin
				if (tbl_done) begin
					tok  = hdr_tok;
					push = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				tok.kind         = KIND_PAYLOAD;
				tok.payload_byte = in_byte;
				tok.segment_end  = seg_done;
				tok.page_end     = seg_done && seg_last;
				push             = 1'b1;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	assign q_push = accept && push;
	assign q_tok  = tok;

	// Only nonzero sizes are kept, packed from entry 0, so the payload walk never
	// has to search past empty segments.
	assign ram_we = accept && (phase_q == PH_TABLE) && store_ok;
	assign ram_re = accept && (phase_q == PH_PAYLOAD) && seg_done && !seg_last;

	odf_ram #(
		.WIDTH(8),
		.DEPTH(MAX_SEGMENTS)
	) u_seg_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(nz_cnt_q[AW-1:0]),
		.wdata(in_byte),
		.re   (ram_re),
		.raddr(raddr_sum[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HEADER;
			hdr_cnt_q       <= 5'd0;
			tbl_idx_q       <= 8'd0;
			nz_cnt_q        <= 8'd0;
			seg_idx_q       <= 8'd0;
			cur_left_q      <= 8'd0;
			next_from_reg_q <= 1'b0;
		end else if (accept) begin
			case (phase_q)
				PH_HEADER: begin
					if (sig_bad) begin
						phase_q <= PH_HALT;
					end else if (hdr_cnt_q == HDR_SEGCOUNT) begin
						hdr_cnt_q <= 5'd0;
						tbl_idx_q <= 8'd0;
						nz_cnt_q  <= 8'd0;
						if (in_byte != 8'd0) begin
							phase_q <= PH_TABLE;
						end
					end else begin
						hdr_cnt_q <= hdr_cnt_q + 5'd1;
					end
				end
				PH_TABLE: begin
					tbl_idx_q <= tbl_sum[7:0];
					nz_cnt_q  <= nz_next;
					if (tbl_done) begin
						if (nz_next == 8'd0) begin
							phase_q   <= PH_HEADER;
							hdr_cnt_q <= 5'd0;
						end else begin
							phase_q         <= PH_PAYLOAD;
							seg_idx_q       <= 8'd0;
							next_from_reg_q <= 1'b1;
							// The first size may arrive with this very byte.
							cur_left_q      <= (nz_cnt_q == 8'd0) ? in_byte : first_q;
						end
					end
				end
				PH_PAYLOAD: begin
					if (!seg_done) begin
						cur_left_q <= left_dec;
					end else if (seg_last) begin
						phase_q   <= PH_HEADER;
						hdr_cnt_q <= 5'd0;
					end else begin
						seg_idx_q       <= seg_idx_q + 8'd1;
						next_from_reg_q <= 1'b0;
						cur_left_q      <= next_from_reg_q ? second_q : ram_rdata;
					end
				end
				default: begin
					phase_q <= PH_HALT;
				end
			endcase
		end
	end

	// Captured fields; each is rewritten on every page before it is used.
	always_ff @(posedge clk) begin
		if (accept && (phase_q == PH_HEADER)) begin
			if (hdr_cnt_q == HDR_VERSION) begin
				version_q <= in_byte;
			end else if (hdr_cnt_q == HDR_FLAGS) begin
				flags_q <= in_byte;
			end else if (hdr_cnt_q >= HDR_GRANULE && hdr_cnt_q < HDR_SERIAL) begin
				granule_q[3'(hdr_cnt_q - HDR_GRANULE) * 8 +: 8] <= in_byte;
			end else if (hdr_cnt_q >= HDR_SERIAL && hdr_cnt_q < HDR_SEQUENCE) begin
				serial_q[2'(hdr_cnt_q - HDR_SERIAL) * 8 +: 8] <= in_byte;
			end else if (hdr_cnt_q >= HDR_SEQUENCE && hdr_cnt_q < HDR_CRC) begin
				sequence_q[2'(hdr_cnt_q - HDR_SEQUENCE) * 8 +: 8] <= in_byte;
			end else if (hdr_cnt_q >= HDR_CRC && hdr_cnt_q < HDR_SEGCOUNT) begin
				crc_q[2'(hdr_cnt_q - HDR_CRC) * 8 +: 8] <= in_byte;
			end else if (hdr_cnt_q == HDR_SEGCOUNT) begin
				segs_q <= in_byte;
			end
		end
		if (ram_we && (nz_cnt_q == 8'd0)) begin
			first_q <= in_byte;
		end
		if (ram_we && (nz_cnt_q == 8'd1)) begin
			second_q <= in_byte;
		end
	end

	`ODF_ASSERT_NEXT(a_halt_sticky, phase_q == PH_HALT, phase_q == PH_HALT, "halt left before reset")
	`ODF_ASSERT(a_left_nonzero, (phase_q != PH_PAYLOAD) || (cur_left_q != 8'd0), "empty segment in payload")
	`ODF_ASSERT(a_seg_in_range, (phase_q != PH_PAYLOAD) || (seg_idx_q < nz_cnt_q), "segment index past table")
	`ODF_ASSERT(a_hdr_cnt_range, hdr_cnt_q <= HDR_SEGCOUNT, "header counter out of range")

endmodule

// ===== rtl/odf_fifo.sv =====
// ---------------------------------------------------------------------------
// Ogg page deframer result queue
// Two-entry queue between the parser and the output stage.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module odf_fifo import odf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  odf_tok_t   push_tok,
	input  logic       pop,
	output odf_tok_t   head_tok,
	output odf_qstat_t stat
);

	odf_tok_t   ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign stat.full  = cnt_q == 2'd2;
	assign stat.empty = cnt_q == 2'd0;
	assign head_tok   = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_tok;
		end
	end

	`ODF_ASSERT(a_no_overflow, !push || (cnt_q != 2'd2), "push into full queue")
	`ODF_ASSERT(a_no_underflow, !pop || (cnt_q != 2'd0), "pop from empty queue")
	`ODF_ASSERT(a_cnt_range, cnt_q <= 2'd2, "queue count out of range")

endmodule

// ===== rtl/odf_back.sv =====
// ---------------------------------------------------------------------------
// Ogg page deframer output stage
// Moves results from the queue into the output register and holds them
// until the downstream side takes the transaction.
// ---------------------------------------------------------------------------
module odf_back import odf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  odf_qstat_t q_stat,
	input  odf_tok_t   head_tok,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output odf_tok_t   out_tok
);

	logic     out_valid_q;
	odf_tok_t out_tok_q;

	assign pop = !q_stat.empty && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_tok_q <= head_tok;
		end
	end

	assign out_valid = out_valid_q;
	assign out_tok   = out_tok_q;

endmodule

// ===== rtl/ogg_page_deframer.sv =====
// ---------------------------------------------------------------------------
// Ogg page deframer
// Splits an Ogg byte stream into page header results and flagged payload bytes.
// ---------------------------------------------------------------------------
// One byte is accepted per clock cycle in every phase while the result queue
// has room; the parser handles each byte as it is accepted and the segment-size
// memory is read one segment ahead, so even one-byte segments keep the full
// rate. Header and segment table bytes give no result, except the byte that
// completes the table (or a zero segment count), which gives one header
// transaction. Each payload byte gives one transaction with segment and page
// end flags. A wrong capture pattern gives one error transaction, after which
// bytes are taken and dropped until reset. Results leave through a two-entry
// queue and then an output register, and input stalls only when both are full.
// No memory clearing is needed after reset.
// ---------------------------------------------------------------------------
module ogg_page_deframer import odf_pkg::*; #(
	parameter int MAX_SEGMENTS = ODF_MAX_SEGMENTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         kind,
	output logic [7:0]         version,
	output logic [7:0]         page_flags,
	output logic signed [63:0] granule_position,
	output logic [31:0]        stream_serial,
	output logic [31:0]        page_sequence,
	output logic [31:0]        crc_field,
	output logic [7:0]         segment_count,
	output logic [7:0]         payload_byte,
	output logic               segment_end,
	output logic               page_end
);

	odf_qstat_t q_stat;
	logic       q_push;
	odf_tok_t   q_tok;
	logic       q_pop;
	odf_tok_t   head_tok;
	odf_tok_t   out_tok;

	odf_front #(
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte (in_byte),
		.q_stat  (q_stat),
		.q_push  (q_push),
		.q_tok   (q_tok)
	);

	odf_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_tok(q_tok),
		.pop     (q_pop),
		.head_tok(head_tok),
		.stat    (q_stat)
	);

	odf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.head_tok (head_tok),
		.pop      (q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_tok  (out_tok)
	);

	assign kind             = out_tok.kind;
	assign version          = out_tok.version;
	assign page_flags       = out_tok.page_flags;
	assign granule_position = $signed(out_tok.granule_position);
	assign stream_serial    = out_tok.stream_serial;
	assign page_sequence    = out_tok.page_sequence;
	assign crc_field        = out_tok.crc_field;
	assign segment_count    = out_tok.segment_count;
	assign payload_byte     = out_tok.payload_byte;
	assign segment_end      = out_tok.segment_end;
	assign page_end         = out_tok.page_end;

endmodule

// ===== test/tb_ogg_page_deframer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Ogg page deframer testbench
// Sends whole Ogg pages byte by byte into the deframer, predicts every header,
// payload and error transaction with a behavioral model, and checks each
// result field by field under several sender and receiver idling patterns.
// ---------------------------------------------------------------------------
module tb_ogg_page_deframer;
	import odf_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LAT_TAIL    = 8;

	typedef enum logic [1:0] {PH_HEADER, PH_TABLE, PH_PAYLOAD, PH_HALT} deframe_phase_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         in_byte = 8'h00;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         kind;
	logic [7:0]         version;
	logic [7:0]         page_flags;
	logic signed [63:0] granule_position;
	logic [31:0]        stream_serial;
	logic [31:0]        page_sequence;
	logic [31:0]        crc_field;
	logic [7:0]         segment_count;
	logic [7:0]         payload_byte;
	logic               segment_end;
	logic               page_end;

	ogg_page_deframer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.version(version),
		.page_flags(page_flags),
		.granule_position(granule_position),
		.stream_serial(stream_serial),
		.page_sequence(page_sequence),
		.crc_field(crc_field),
		.segment_count(segment_count),
		.payload_byte(payload_byte),
		.segment_end(segment_end),
		.page_end(page_end)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	int snd_idle_pct = 14;
	int rcv_idle_pct = 61;
	int err_cnt = 0;
	int tok_cnt = 0;
	int bytes_sent = 0;
	int cycle_cnt = 0;

	odf_tok_t pending_tokens[$];
	odf_tok_t want;

	// Segment sizes of the page that the next send_page call builds.
	logic [7:0] plan_sizes [0:254];

	// Deframer state as predicted from the accepted bytes.
	deframe_phase_t m_phase = PH_HEADER;
	logic [4:0]  m_hdr_cnt = '0;
	logic [7:0]  m_version = '0;
	logic [7:0]  m_flags = '0;
	logic [63:0] m_granule = '0;
	logic [31:0] m_serial = '0;
	logic [31:0] m_sequence = '0;
	logic [31:0] m_crc = '0;
	int          m_nseg = 0;
	logic [7:0]  m_seg_len [0:254];
	int          m_seg_idx = 0;
	int          m_left = 0;

	function automatic int seg_size(input int i);
		if (i < ODF_MAX_SEGMENTS && i < m_nseg)
			return int'(m_seg_len[i]);
		return 0;
	endfunction

	function automatic int next_filled(input int start);
		int i;
		i = start;
		while (i < m_nseg && seg_size(i) == 0)
			i++;
		return i;
	endfunction

	task automatic deframe_byte(input logic [7:0] b);
		odf_tok_t t;
		odf_tok_t hdr;
		int n;
		int sh;
		t = '0;
		hdr = '0;
		hdr.kind = KIND_HEADER;
		case (m_phase)
			PH_HALT: ;
			PH_HEADER: begin
				if (m_hdr_cnt < HDR_VERSION && b != CAPTURE[m_hdr_cnt[1:0]]) begin
					m_phase = PH_HALT;
					t.kind = KIND_ERROR;
					pending_tokens.push_back(t);
				end else begin
					if (m_hdr_cnt == HDR_VERSION) begin
						m_version = b;
					end else if (m_hdr_cnt == HDR_FLAGS) begin
						m_flags = b;
					end else if (m_hdr_cnt >= HDR_GRANULE && m_hdr_cnt < HDR_SERIAL) begin
						sh = (int'(m_hdr_cnt) - int'(HDR_GRANULE)) * 8;
						m_granule[sh +: 8] = b;
					end else if (m_hdr_cnt >= HDR_SERIAL && m_hdr_cnt < HDR_SEQUENCE) begin
						sh = (int'(m_hdr_cnt) - int'(HDR_SERIAL)) * 8;
						m_serial[sh +: 8] = b;
					end else if (m_hdr_cnt >= HDR_SEQUENCE && m_hdr_cnt < HDR_CRC) begin
						sh = (int'(m_hdr_cnt) - int'(HDR_SEQUENCE)) * 8;
						m_sequence[sh +: 8] = b;
					end else if (m_hdr_cnt >= HDR_CRC && m_hdr_cnt < HDR_SEGCOUNT) begin
						sh = (int'(m_hdr_cnt) - int'(HDR_CRC)) * 8;
						m_crc[sh +: 8] = b;
					end else if (m_hdr_cnt == HDR_SEGCOUNT) begin
						m_nseg = int'(b);
					end
					if (m_hdr_cnt == HDR_SEGCOUNT) begin
						m_hdr_cnt = '0;
						m_seg_idx = 0;
						if (m_nseg == 0) begin
							hdr.version = m_version;
							hdr.page_flags = m_flags;
							hdr.granule_position = m_granule;
							hdr.stream_serial = m_serial;
							hdr.page_sequence = m_sequence;
							hdr.crc_field = m_crc;
							hdr.segment_count = 8'(m_nseg);
							pending_tokens.push_back(hdr);
						end else begin
							m_phase = PH_TABLE;
						end
					end else begin
						m_hdr_cnt = m_hdr_cnt + 5'd1;
					end
				end
			end
			PH_TABLE: begin
				if (m_seg_idx < ODF_MAX_SEGMENTS)
					m_seg_len[m_seg_idx] = b;
				m_seg_idx = (m_seg_idx + 1) & 255;
				if (m_seg_idx >= m_nseg) begin
					hdr.version = m_version;
					hdr.page_flags = m_flags;
					hdr.granule_position = m_granule;
					hdr.stream_serial = m_serial;
					hdr.page_sequence = m_sequence;
					hdr.crc_field = m_crc;
					hdr.segment_count = 8'(m_nseg);
					pending_tokens.push_back(hdr);
					// A table of only empty segments goes straight to the next page.
					n = next_filled(0);
					if (n >= m_nseg) begin
						m_phase = PH_HEADER;
						m_hdr_cnt = '0;
					end else begin
						m_phase = PH_PAYLOAD;
						m_seg_idx = n;
						m_left = seg_size(n);
					end
				end
			end
			PH_PAYLOAD: begin
				t.kind = KIND_PAYLOAD;
				t.payload_byte = b;
				if (m_left > 0)
					m_left--;
				if (m_left == 0) begin
					n = next_filled(m_seg_idx + 1);
					t.segment_end = 1'b1;
					if (n >= m_nseg) begin
						t.page_end = 1'b1;
						m_phase = PH_HEADER;
						m_hdr_cnt = '0;
						m_seg_idx = 0;
					end else begin
						m_seg_idx = n & 255;
						m_left = seg_size(n);
					end
				end
				pending_tokens.push_back(t);
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		$display("MISMATCH %s: got %h, wanted %h (token %0d)", what, got, exp_val, tok_cnt);
		err_cnt++;
	endtask

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);

	// Every output transaction is matched against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_tokens.size() == 0) begin
				report_mismatch("transaction with nothing pending", 64'(kind), 64'd0);
			end else begin
				want = pending_tokens.pop_front();
				if (kind != want.kind)
					report_mismatch("kind", 64'(kind), 64'(want.kind));
				if (version != want.version)
					report_mismatch("version", 64'(version), 64'(want.version));
				if (page_flags != want.page_flags)
					report_mismatch("page_flags", 64'(page_flags), 64'(want.page_flags));
				if (granule_position != want.granule_position)
					report_mismatch("granule_position", granule_position,
						want.granule_position);
				if (stream_serial != want.stream_serial)
					report_mismatch("stream_serial", 64'(stream_serial),
						64'(want.stream_serial));
				if (page_sequence != want.page_sequence)
					report_mismatch("page_sequence", 64'(page_sequence),
						64'(want.page_sequence));
				if (crc_field != want.crc_field)
					report_mismatch("crc_field", 64'(crc_field), 64'(want.crc_field));
				if (segment_count != want.segment_count)
					report_mismatch("segment_count", 64'(segment_count),
						64'(want.segment_count));
				if (payload_byte != want.payload_byte)
					report_mismatch("payload_byte", 64'(payload_byte),
						64'(want.payload_byte));
				if (segment_end != want.segment_end)
					report_mismatch("segment_end", 64'(segment_end), 64'(want.segment_end));
				if (page_end != want.page_end)
					report_mismatch("page_end", 64'(page_end), 64'(want.page_end));
			end
			tok_cnt++;
		end
	end

	// Called at a rising edge; returns at the edge where the byte is taken.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		deframe_byte(b);
		bytes_sent++;
	endtask

	task automatic send_page(input logic [7:0] ver, input logic [7:0] flags,
			input logic [63:0] gran, input logic [31:0] ser, input logic [31:0] seq,
			input logic [31:0] crc, input int nseg);
		int i;
		for (i = 0; i < 4; i++)
			send_byte(CAPTURE[i]);
		send_byte(ver);
		send_byte(flags);
		for (i = 0; i < 8; i++)
			send_byte(gran[i*8 +: 8]);
		for (i = 0; i < 4; i++)
			send_byte(ser[i*8 +: 8]);
		for (i = 0; i < 4; i++)
			send_byte(seq[i*8 +: 8]);
		for (i = 0; i < 4; i++)
			send_byte(crc[i*8 +: 8]);
		send_byte(8'(nseg));
		for (i = 0; i < nseg; i++)
			send_byte(plan_sizes[i]);
		for (i = 0; i < nseg; i++)
			repeat (plan_sizes[i]) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic wait_drained;
		in_valid <= 1'b0;
		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (LAT_TAIL) @(posedge clk);
	endtask

	task automatic test_empty_pages;
		send_page(8'h00, 8'h00, 64'h0, 32'h0, 32'h0, 32'h0, 0);
		send_page(8'hFF, 8'hFF, '1, '1, '1, '1, 0);
		plan_sizes[0] = 8'd0;
		plan_sizes[1] = 8'd0;
		plan_sizes[2] = 8'd0;
		send_page(8'h01, 8'h02, 64'h8000_0000_0000_0000, 32'h8000_0001, 32'h1,
			32'hDEAD_BEEF, 3);
	endtask

	task automatic test_segment_shapes;
		int i;
		for (i = 0; i < 4; i++)
			plan_sizes[i] = 8'd1;
		send_page(8'h00, 8'h01, 64'h7FFF_FFFF_FFFF_FFFF, 32'h1234_5678, 32'h2, 32'h0, 4);
		// Empty segments at the start, in the middle and at the end are skipped.
		plan_sizes[0] = 8'd0;
		plan_sizes[1] = 8'd3;
		plan_sizes[2] = 8'd0;
		plan_sizes[3] = 8'd0;
		plan_sizes[4] = 8'd2;
		plan_sizes[5] = 8'd0;
		send_page(8'h00, 8'h00, 64'h1, 32'h1234_5678, 32'h3, 32'hA5A5_5A5A, 6);
		plan_sizes[0] = 8'd255;
		plan_sizes[1] = 8'd0;
		send_page(8'h00, 8'h04, 64'hFFFF_FFFF_FFFF_FFFE, 32'h0, 32'hFFFF_FFFF, 32'h5, 2);
		for (i = 0; i < 255; i++)
			plan_sizes[i] = 8'd0;
		plan_sizes[0] = 8'd1;
		plan_sizes[127] = 8'd2;
		plan_sizes[254] = 8'd1;
		send_page(8'h80, 8'h00, 64'h0123_4567_89AB_CDEF, 32'hFFFF_0000, 32'h4,
			32'h0F0F_F0F0, 255);
	endtask

	task automatic test_random_pages(input int snd_pct, input int rcv_pct,
			input int byte_budget);
		int start;
		int nseg;
		int r;
		int i;
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		start = bytes_sent;
		while (bytes_sent - start < byte_budget) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				nseg = 0;
			else if (r < 88)
				nseg = $urandom_range(1, 6);
			else if (r < 97)
				nseg = $urandom_range(7, 24);
			else
				nseg = $urandom_range(200, 255);
			for (i = 0; i < nseg; i++) begin
				r = $urandom_range(0, 99);
				if (nseg >= 200)
					plan_sizes[i] = (r < 5) ? 8'($urandom_range(1, 3)) : 8'd0;
				else if (r < 15)
					plan_sizes[i] = 8'd0;
				else if (r < 75)
					plan_sizes[i] = 8'($urandom_range(1, 8));
				else if (r < 95)
					plan_sizes[i] = 8'($urandom_range(9, 40));
				else
					plan_sizes[i] = 8'($urandom_range(200, 255));
			end
			send_page(8'($urandom), 8'($urandom), {$urandom, $urandom}, $urandom,
				$urandom, $urandom, nseg);
		end
	endtask

	// The block halts for good after a bad capture pattern, so this runs last.
	task automatic test_bad_signature;
		int pos;
		int i;
		logic [7:0] bad;
		pos = $urandom_range(0, 3);
		for (i = 0; i < pos; i++)
			send_byte(CAPTURE[i]);
		do
			bad = 8'($urandom_range(0, 255));
		while (bad == CAPTURE[pos]);
		send_byte(bad);
		repeat (12) send_byte(8'($urandom_range(0, 255)));
		plan_sizes[0] = 8'd2;
		send_page(8'h00, 8'h00, 64'h5, 32'h6, 32'h7, 32'h8, 1);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_pages;
		test_segment_shapes;
		wait_drained;
		test_random_pages(14, 61, 40);
		wait_drained;
		test_random_pages(61, 14, 40);
		wait_drained;
		test_random_pages(0, 0, 30);
		test_bad_signature;
		wait_drained;
		if (pending_tokens.size() != 0)
			report_mismatch("transactions never produced", 64'(pending_tokens.size()), 64'd0);
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/odf_pkg.sv
rtl/odf_ram.sv
rtl/odf_front.sv
rtl/odf_fifo.sv
rtl/odf_back.sv
rtl/ogg_page_deframer.sv
test/tb_ogg_page_deframer.sv
